### sv/idp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idp_pkg
// Shared widths, codes and helpers for the id pool allocator.
// ----------------------------------------------------------------------------
package idp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int SUM_W      = IDX_W + 1;

  localparam int ID_W   = 31;
  localparam int MODE_W = 2;
  localparam int ST_W   = 3;

  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NOT_IN_USE = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  // circular free-list position head + off, wrapped at the pool depth
  function automatic logic [IDX_W-1:0] free_slot(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= SUM_W'(POOL_DEPTH)) begin
      sum = sum - SUM_W'(POOL_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### sv/idp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idp_if
// Request and response channels of the id pool allocator.
// ----------------------------------------------------------------------------
interface idp_req_if import idp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   id;

  modport source (output valid, output mode, output id, input ready);
  modport sink   (input valid, input mode, input id, output ready);
endinterface

interface idp_rsp_if import idp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_id;
  logic [ST_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

### sv/idp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/id_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_pool_allocator_core
// Bounded id pool: FIFO free list plus in-use set, searched one entry a step.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request beat (mode, id): add id, acquire, release id.
//   out_o returns exactly one response beat per request (granted_id, status).
//   The block works on one request at a time; in_i.ready is high only while
//   the sequencer is idle. Adds and releases are searched entry by entry
//   through a single 31-bit comparator reading the free list and the in-use
//   store respectively; both stores are RAMs with registered read data.
//   Steps from accept to response loaded into the output register:
//     add      : compare each free entry in turn; push the id if no duplicate
//     acquire  : find the first empty in-use slot, move the free-list head in
//     release  : compare each valid in-use slot; push the id back on a match
//     empty acquire, no-op : straight to the result
//   The next request can be taken in the cycle after the response is loaded.
//   After reset the free list is empty and no slot is in use; no clearing
//   pass is needed. A stalled out_o holds its beat; the finished result then
//   waits in the sequencer and the next request is not taken until it moves.
// ----------------------------------------------------------------------------
module id_pool_allocator_core import idp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  idp_req_if.sink   in_i,
  idp_rsp_if.source out_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_RD   = 4'd1;
  localparam logic [3:0] S_ADD_CMP  = 4'd2;
  localparam logic [3:0] S_PUSH     = 4'd3;
  localparam logic [3:0] S_ACQ_SCAN = 4'd4;
  localparam logic [3:0] S_ACQ_WR   = 4'd5;
  localparam logic [3:0] S_REL_SCAN = 4'd6;
  localparam logic [3:0] S_REL_CMP  = 4'd7;
  localparam logic [3:0] S_PUT      = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [IDX_W-1:0]      k_q, k_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  status_e               res_st_q, res_st_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [POOL_DEPTH-1:0] used_valid_q, used_valid_d;
  logic                  out_valid_q, out_valid_d;
  logic [ID_W-1:0]       out_id_q, out_id_d;
  logic [ST_W-1:0]       out_st_q, out_st_d;

  logic                  in_fire;
  logic                  free_re, free_we, used_re, used_we;
  logic [IDX_W-1:0]      free_raddr, free_waddr;
  logic [ID_W-1:0]       free_rdata, used_rdata, cmp_data;
  logic                  id_match, add_last, used_last, pool_full;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // the one shared comparator: free entries on add, in-use entries on release
  assign cmp_data  = (state_q == S_ADD_CMP) ? free_rdata : used_rdata;
  assign id_match  = (cmp_data == id_q);

  assign add_last  = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
  assign used_last = (k_q == IDX_W'(POOL_DEPTH - 1));
  assign pool_full = (count_q == CNT_W'(POOL_DEPTH));

  assign free_raddr = (state_q == S_ACQ_SCAN) ? head_q : free_slot(head_q, k_q);
  assign free_waddr = free_slot(head_q, count_q[IDX_W-1:0]);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    slot_d       = slot_q;
    id_d         = id_q;
    res_id_d     = res_id_q;
    res_st_d     = res_st_q;
    head_d       = head_q;
    count_d      = count_q;
    used_valid_d = used_valid_q;
    out_valid_d  = out_valid_q;
    out_id_d     = out_id_q;
    out_st_d     = out_st_q;
    free_re      = 1'b0;
    free_we      = 1'b0;
    used_re      = 1'b0;
    used_we      = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          id_d     = in_i.id;
          k_d      = '0;
          res_id_d = '0;
          res_st_d = ST_OK;
          case (in_i.mode)
            MODE_ADD: begin
              state_d = (count_q == '0) ? S_PUSH : S_ADD_RD;
            end
            MODE_ACQUIRE: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_PUT;
              end else begin
                state_d = S_ACQ_SCAN;
              end
            end
            MODE_RELEASE: state_d = S_REL_SCAN;
            default:      state_d = S_PUT;
          endcase
        end
      end
      S_ADD_RD: begin
        free_re = 1'b1;
        state_d = S_ADD_CMP;
      end
      S_ADD_CMP: begin
        if (id_match) begin
          res_st_d = ST_DUPLICATE;
          state_d  = S_PUT;
        end else if (add_last) begin
          state_d = S_PUSH;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = S_ADD_RD;
        end
      end
      S_PUSH: begin
        if (pool_full) begin
          res_st_d = ST_FULL;
        end else begin
          free_we = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        state_d = S_PUT;
      end
      S_ACQ_SCAN: begin
        if (!used_valid_q[k_q]) begin
          slot_d  = k_q;
          free_re = 1'b1;
          state_d = S_ACQ_WR;
        end else if (used_last) begin
          res_st_d = ST_FULL;
          state_d  = S_PUT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_ACQ_WR: begin
        used_we              = 1'b1;
        used_valid_d[slot_q] = 1'b1;
        res_id_d             = free_rdata;
        head_d               = free_slot(head_q, IDX_W'(1));
        count_d              = count_q - CNT_W'(1);
        state_d              = S_PUT;
      end
      S_REL_SCAN: begin
        if (used_valid_q[k_q]) begin
          used_re = 1'b1;
          state_d = S_REL_CMP;
        end else if (used_last) begin
          res_st_d = ST_NOT_IN_USE;
          state_d  = S_PUT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_REL_CMP: begin
        if (id_match) begin
          if (pool_full) begin
            res_st_d = ST_FULL;
            state_d  = S_PUT;
          end else begin
            used_valid_d[k_q] = 1'b0;
            state_d           = S_PUSH;
          end
        end else if (used_last) begin
          res_st_d = ST_NOT_IN_USE;
          state_d  = S_PUT;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = S_REL_SCAN;
        end
      end
      S_PUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_id_d    = res_id_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      used_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      used_valid_q <= used_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    slot_q   <= slot_d;
    id_q     <= id_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    out_id_q <= out_id_d;
    out_st_q <= out_st_d;
  end

  idp_ram #(.WIDTH(ID_W), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (id_q),
    .re_i    (free_re),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  idp_ram #(.WIDTH(ID_W), .DEPTH(POOL_DEPTH)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (slot_q),
    .wdata_i (free_rdata),
    .re_i    (used_re),
    .raddr_i (k_q),
    .rdata_o (used_rdata)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.granted_id = out_id_q;
  assign out_o.status     = out_st_q;

  // free count never goes past the pool depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(POOL_DEPTH))
    else $error("free count exceeds pool depth");

  // an accepted request always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  // a nonzero id is only handed out with an ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> out_o.granted_id == '0)
    else $error("granted id on a failed response");

  // a successful acquire marks exactly one more in-use slot
  a_acq_marks_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACQ_WR) |=>
      $countones(used_valid_q) == $countones($past(used_valid_q)) + 1)
    else $error("acquire did not claim an in-use slot");

  // a new response beat only comes out of the result state
  a_beat_from_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(state_q) == S_PUT)
    else $error("response beat without a finished request");

endmodule

### tb/sv/id_pool_allocator_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_pool_allocator_core_checker
// Watches the request and response channels of the id pool allocator. It
// keeps its own copy of the free list and the in-use set and predicts each
// response. Responses are compared in order, field by field.
// ----------------------------------------------------------------------------
module id_pool_allocator_core_checker import idp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  idp_req_if   req_mon,
  idp_rsp_if   rsp_mon,
  output int   errors_o,
  output int   pending_o
);

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    status_e         status;
  } grant_t;

  logic [ID_W-1:0]       free_ids [POOL_DEPTH];
  logic [IDX_W-1:0]      free_head;
  logic [CNT_W-1:0]      free_count;
  logic [ID_W-1:0]       used_ids [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] used_valid;

  grant_t grants_due[$];

  function automatic int free_pos(input int off);
    return (int'(free_head) + off) % POOL_DEPTH;
  endfunction

  function automatic void free_append(input logic [ID_W-1:0] id);
    free_ids[free_pos(int'(free_count))] = id;
    free_count = free_count + 1'b1;
  endfunction

  // applies one request to the shadow pool and returns its response
  function automatic grant_t pool_step(input logic [MODE_W-1:0] mode,
                                       input logic [ID_W-1:0] id);
    grant_t res;
    int     slot;
    bit     hit;
    res.granted_id = '0;
    res.status     = ST_OK;
    slot           = POOL_DEPTH;
    hit            = 1'b0;
    case (mode)
      MODE_ADD: begin
        for (int k = 0; k < int'(free_count); k++) begin
          if (free_ids[free_pos(k)] == id) hit = 1'b1;
        end
        if (hit) begin
          res.status = ST_DUPLICATE;
        end else if (free_count >= CNT_W'(POOL_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          free_append(id);
        end
      end
      MODE_ACQUIRE: begin
        if (free_count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int k = POOL_DEPTH - 1; k >= 0; k--) begin
            if (!used_valid[k]) slot = k;
          end
          if (slot >= POOL_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            res.granted_id   = free_ids[free_head];
            used_ids[slot]   = res.granted_id;
            used_valid[slot] = 1'b1;
            free_head        = IDX_W'(free_pos(1));
            free_count       = free_count - 1'b1;
          end
        end
      end
      MODE_RELEASE: begin
        // lowest-numbered matching slot wins when an id is in use twice
        for (int k = POOL_DEPTH - 1; k >= 0; k--) begin
          if (used_valid[k] && used_ids[k] == id) slot = k;
        end
        if (slot >= POOL_DEPTH) begin
          res.status = ST_NOT_IN_USE;
        end else if (free_count >= CNT_W'(POOL_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          used_valid[slot] = 1'b0;
          free_append(id);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      free_head  = '0;
      free_count = '0;
      used_valid = '0;
      grants_due.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        grants_due.insert(grants_due.size(), pool_step(req_mon.mode, req_mon.id));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grants_due.size() == 0) begin
          $error("response beat with no request outstanding: granted_id %0h status %0d",
                 rsp_mon.granted_id, rsp_mon.status);
          errors_o = errors_o + 1;
        end else begin
          want = grants_due.pop_front();
          if (rsp_mon.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0h, actual %0h", want.granted_id,
                   rsp_mon.granted_id);
            errors_o = errors_o + 1;
          end
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
            errors_o = errors_o + 1;
          end
        end
      end
      pending_o = grants_due.size();
    end
  end

endmodule

### tb/sv/id_pool_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_pool_allocator_core_tb
// Drives add, acquire, release and idle requests into the id pool allocator
// through four flow-control phases, with a short directed opening and then
// random bursts that fill, drain and churn the pool. Ids mostly come from a
// small set so that duplicates, releases that hit and full stores are common.
// ----------------------------------------------------------------------------
module id_pool_allocator_core_tb;
  import idp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int BURST_LEN       = 10;
  localparam int ID_SET_SIZE     = 24;
  localparam int DRAIN_CYCLES    = 60;
  localparam int STALL_LIMIT     = 5000;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_CHURN} bias_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  idp_req_if req_if ();
  idp_rsp_if rsp_if ();

  int errors;
  int pending;
  int idle_pct;
  int stall_pct;
  int n_add, n_acquire, n_release, n_nop;
  int idle_cycles;

  logic [ID_W-1:0] id_set [ID_SET_SIZE];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  id_pool_allocator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  id_pool_allocator_core_checker u_scoreboard (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_if),
    .rsp_mon   (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: too long without any beat on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("id_pool_allocator_core_tb: done, errors");
    $finish;
  end

  task automatic send_req(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= mode;
    req_if.id    <= id;
    do @(posedge clk_i); while (!req_if.ready);
    case (mode)
      MODE_ADD:     n_add++;
      MODE_ACQUIRE: n_acquire++;
      MODE_RELEASE: n_release++;
      default:      n_nop++;
    endcase
  endtask

  // drop valid and hold off until every response is back
  task automatic drain_pool;
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [ID_W-1:0] pick_id;
    if ($urandom_range(99) < 15) return ID_W'($urandom());
    return id_set[$urandom_range(ID_SET_SIZE - 1)];
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input bias_e bias);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return MODE_NOP;
    case (bias)
      BIAS_FILL:  return (roll < 75) ? MODE_ADD : (roll < 88) ? MODE_ACQUIRE : MODE_RELEASE;
      BIAS_DRAIN: return (roll < 20) ? MODE_ADD : (roll < 80) ? MODE_ACQUIRE : MODE_RELEASE;
      default:    return (roll < 37) ? MODE_ADD : (roll < 68) ? MODE_ACQUIRE : MODE_RELEASE;
    endcase
  endfunction

  task automatic run_directed;
    logic [ID_W-1:0] max_id;
    logic [ID_W-1:0] alt_a;
    logic [ID_W-1:0] alt_b;
    max_id = '1;
    alt_a  = 31'h2AAA_AAAA;
    alt_b  = 31'h5555_5555;
    send_req(MODE_ACQUIRE, max_id);   // empty pool
    send_req(MODE_RELEASE, 31'd5);    // nothing in use
    send_req(MODE_ADD, '0);
    send_req(MODE_ADD, max_id);
    send_req(MODE_ADD, '0);           // already free
    send_req(MODE_ACQUIRE, '0);       // hands out id zero
    send_req(MODE_ACQUIRE, alt_b);
    send_req(MODE_ACQUIRE, '0);       // empty again
    send_req(MODE_ADD, alt_a);
    send_req(MODE_ADD, alt_b);
    send_req(MODE_ACQUIRE, '0);
    send_req(MODE_ADD, alt_a);        // in use, but add only checks the free list
    send_req(MODE_ACQUIRE, '0);
    send_req(MODE_ACQUIRE, '0);       // same id now in use twice
    send_req(MODE_RELEASE, alt_a);
    send_req(MODE_RELEASE, alt_a);
    send_req(MODE_RELEASE, alt_a);    // no longer in use
    send_req(MODE_NOP, max_id);
    send_req(MODE_NOP, alt_b);
    send_req(MODE_RELEASE, '0);
    send_req(MODE_RELEASE, max_id);
    send_req(MODE_RELEASE, alt_b);
  endtask

  initial begin
    bias_e bias;
    int    sent;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_ADD;
    req_if.id      = '0;
    rsp_if.ready   = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    n_add          = 0;
    n_acquire      = 0;
    n_release      = 0;
    n_nop          = 0;
    id_set[0]      = '0;
    id_set[1]      = '1;
    id_set[2]      = 31'h2AAA_AAAA;
    id_set[3]      = 31'h5555_5555;
    for (int k = 4; k < ID_SET_SIZE; k++) id_set[k] = ID_W'($urandom());
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      sent = 0;
      if (phase == 0) begin
        run_directed();
        drain_pool();
      end
      while (sent < ITEMS_PER_PHASE) begin
        // open each phase by filling so the full-store cases come up early
        bias = (sent == 0) ? BIAS_FILL : bias_e'($urandom_range(2));
        for (int k = 0; k < BURST_LEN; k++) begin
          send_req(pick_mode(bias), pick_id());
          sent++;
        end
        if ($urandom_range(99) < 20) drain_pool();
      end
      drain_pool();
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: %0d add, %0d acquire, %0d release, %0d no-op",
             n_add + n_acquire + n_release + n_nop, n_add, n_acquire, n_release, n_nop);
    $display("four flow-control phases: free-running, sender gaps, receiver stalls, both");
    if (errors == 0) begin
      $display("id_pool_allocator_core_tb: done, clean");
    end else begin
      $display("id_pool_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
